// ===== design/stbs_pkg.sv =====
// Package for the sort-then-search block: sizes, opcodes and the bus that reaches every cell.
// Used by every module in the design folder; it depends on nothing.
package stbs_pkg;

    localparam int DEPTH  = 256;
    localparam int DATA_W = 32;
    localparam int POS_W  = 8;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic
    {
        OP_LOAD   = 1'b0,
        OP_SEARCH = 1'b1
    } op_t;

    typedef struct packed
    {
        logic              ins;
        logic              cmp;
        logic [DATA_W-1:0] element;
        logic [DATA_W-1:0] key;
    } cell_bus_t;

endpackage

// ===== design/sort_then_binary_search.sv =====
// Top level of the sort-then-search block: element count, overflow mark, cell chain, search.
// Depends on stbs_pkg, stbs_chain and stbs_search.
//
//  Channel  | Handshake                   | Payload
//  ---------+-----------------------------+----------------------------------
//  command  | start high while busy low   | op, element, start_set, key
//  result   | done high for one cycle     | found, position, overflowed
//
// In a load transaction the chain of cells inserts the element in order at once,
// so the set is always ascending and a new load may follow in the next cycle.
// A search transaction holds busy while it probes, halving the search interval at each probe,
// and done rises in the cycle after the last probe.
// Reset empties the set and clears the overflow mark; no clearing pass is needed.
// The receiver cannot stall results, so nothing in the block waits on the result side.
module sort_then_binary_search
    import stbs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     op,
    input  logic signed [DATA_W-1:0] element,
    input  logic                     start_set,
    input  logic signed [DATA_W-1:0] key,
    output logic                     done,
    output logic                     found,
    output logic [POS_W-1:0]         position,
    output logic                     overflowed
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic [CNT_W-1:0] count_eff;
    logic             load_acc;
    logic             search_acc;
    logic             full;
    cell_bus_t        bus;
    logic [DEPTH-1:0] eq_vec;
    logic [DEPTH-1:0] lt_vec;

    assign load_acc   = start && !busy && (op == OP_LOAD);
    assign search_acc = start && !busy && (op == OP_SEARCH);
    assign count_eff  = (load_acc && start_set) ? '0 : count_reg;
    assign full       = (count_eff == CNT_W'(DEPTH));

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (load_acc)
        begin
            count_next = full ? count_eff : count_eff + CNT_W'(1);
            ovf_next   = (start_set ? 1'b0 : ovf_reg) | full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign bus.ins     = load_acc && !full;
    assign bus.cmp     = search_acc;
    assign bus.element = element;
    assign bus.key     = key;

    stbs_chain u_chain
    (
        .clk    (clk),
        .bus    (bus),
        .count  (count_eff),
        .eq_vec (eq_vec),
        .lt_vec (lt_vec)
    );

    stbs_search u_search
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (search_acc),
        .count      (count_reg),
        .ovf        (ovf_reg),
        .eq_vec     (eq_vec),
        .lt_vec     (lt_vec),
        .busy       (busy),
        .done       (done),
        .found      (found),
        .position   (position),
        .overflowed (overflowed)
    );

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("element count exceeds the store depth");

    a_full_load_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (load_acc && !start_set && (count_reg == CNT_W'(DEPTH))) |=> ovf_reg)
        else $error("dropped load did not set the overflow mark");

    a_count_held_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> $stable(count_reg))
        else $error("element count changed during a search");

endmodule

// ===== design/stbs_cell.sv =====
// One cell of the sorted chain: holds one element and its comparison flags for a search.
// Depends on stbs_pkg.
module stbs_cell
    import stbs_pkg::*;
(
    input  logic              clk,
    input  cell_bus_t         bus,
    input  logic              occ,
    input  logic              prev_gt,
    input  logic [DATA_W-1:0] prev_value,
    output logic              gt,
    output logic [DATA_W-1:0] value,
    output logic              eq_flag,
    output logic              lt_flag
);

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;
    logic              eq_reg;
    logic              eq_next;
    logic              lt_reg;
    logic              lt_next;

    // A cell is displaced when it is empty or holds a value greater than the new element.
    assign gt = !occ || ($signed(value_reg) > $signed(bus.element));

    always_comb
    begin
        value_next = value_reg;
        eq_next    = eq_reg;
        lt_next    = lt_reg;
        if (bus.ins && gt)
        begin
            value_next = prev_gt ? prev_value : bus.element;
        end
        if (bus.cmp)
        begin
            eq_next = (value_reg == bus.key);
            lt_next = ($signed(bus.key) < $signed(value_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        eq_reg    <= eq_next;
        lt_reg    <= lt_next;
    end

    assign value   = value_reg;
    assign eq_flag = eq_reg;
    assign lt_flag = lt_reg;

endmodule

// ===== design/stbs_chain.sv =====
// The row of cells that keeps the stored set in ascending order as elements arrive.
// Depends on stbs_pkg and stbs_cell.
module stbs_chain
    import stbs_pkg::*;
(
    input  logic             clk,
    input  cell_bus_t        bus,
    input  logic [CNT_W-1:0] count,
    output logic [DEPTH-1:0] eq_vec,
    output logic [DEPTH-1:0] lt_vec
);

    logic [DATA_W-1:0] value_vec [DEPTH];
    logic [DEPTH-1:0]  gt_vec;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
        logic              occ;
        logic              prev_gt;
        logic [DATA_W-1:0] prev_value;

        assign occ = (IDX < count);

        if (i == 0)
        begin : g_first
            assign prev_gt    = 1'b0;
            assign prev_value = bus.element;
        end
        else
        begin : g_rest
            assign prev_gt    = gt_vec[i-1];
            assign prev_value = value_vec[i-1];
        end

        stbs_cell u_cell
        (
            .clk        (clk),
            .bus        (bus),
            .occ        (occ),
            .prev_gt    (prev_gt),
            .prev_value (prev_value),
            .gt         (gt_vec[i]),
            .value      (value_vec[i]),
            .eq_flag    (eq_vec[i]),
            .lt_flag    (lt_vec[i])
        );
    end

endmodule

// ===== design/stbs_search.sv =====
// Binary search sequencer: one probe of the cells' comparison flags per cycle.
// Depends on stbs_pkg.
module stbs_search
    import stbs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [CNT_W-1:0] count,
    input  logic             ovf,
    input  logic [DEPTH-1:0] eq_vec,
    input  logic [DEPTH-1:0] lt_vec,
    output logic             busy,
    output logic             done,
    output logic             found,
    output logic [POS_W-1:0] position,
    output logic             overflowed
);

    localparam int SW = CNT_W + 1;

    typedef enum logic
    {
        S_IDLE,
        S_PROBE
    } state_t;

    state_t                state_reg;
    logic signed [SW-1:0]  lo_reg;
    logic signed [SW-1:0]  hi_reg;
    logic                  done_reg;
    logic                  found_reg;
    logic [POS_W-1:0]      position_reg;
    logic                  overflowed_reg;
    logic signed [SW:0]    sum;
    logic [IDX_W-1:0]      mid;
    logic signed [SW-1:0]  mid_s;

    assign sum   = (SW+1)'(lo_reg) + (SW+1)'(hi_reg);
    assign mid   = sum[IDX_W:1];
    assign mid_s = $signed({{(SW-IDX_W){1'b0}}, mid});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            lo_reg         <= '0;
            hi_reg         <= '0;
            done_reg       <= 1'b0;
            found_reg      <= 1'b0;
            position_reg   <= '0;
            overflowed_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (go)
                    begin
                        lo_reg    <= '0;
                        hi_reg    <= $signed({1'b0, count}) - SW'(1);
                        state_reg <= S_PROBE;
                    end
                end
                S_PROBE:
                begin
                    priority if (lo_reg > hi_reg)
                    begin
                        done_reg       <= 1'b1;
                        found_reg      <= 1'b0;
                        position_reg   <= '0;
                        overflowed_reg <= ovf;
                        state_reg      <= S_IDLE;
                    end
                    else if (eq_vec[mid])
                    begin
                        done_reg       <= 1'b1;
                        found_reg      <= 1'b1;
                        position_reg   <= POS_W'(mid);
                        overflowed_reg <= ovf;
                        state_reg      <= S_IDLE;
                    end
                    else if (lt_vec[mid])
                    begin
                        hi_reg <= mid_s - SW'(1);
                    end
                    else
                    begin
                        lo_reg <= mid_s + SW'(1);
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy       = (state_reg == S_PROBE);
    assign done       = done_reg;
    assign found      = found_reg;
    assign position   = position_reg;
    assign overflowed = overflowed_reg;

    a_done_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_PROBE))
        else $error("result strobe without a preceding probe");

    a_lo_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> (lo_reg >= 0))
        else $error("search lower bound went negative");

    a_hi_in_set: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> (hi_reg < $signed({1'b0, count})))
        else $error("search upper bound beyond the stored set");

endmodule
